// ===== sv/bmm_pkg.sv =====
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types and constants of the block motion mask: queue entry between
// the front and back parts, result record and configuration bundle.
// ----------------------------------------------------------------------------
package bmm_pkg;

  // Width of a cell coordinate carried through the queue (grid up to 128).
  localparam int CIDX_W = 7;

  // The cell sum is scaled down by this shift before the threshold compare.
  localparam int MOTION_SHIFT = 6;

  // Queue depths; both must be powers of two.
  localparam int ITEM_QUEUE_DEPTH   = 4;
  localparam int RESULT_QUEUE_DEPTH = 2;

  // Input function codes and result kinds.
  localparam logic FUNC_QUERY = 1'b1;
  localparam logic KIND_CELL  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic REG_THRESHOLD  = 1'b0;
  localparam logic REG_MIN_ACTIVE = 1'b1;

  // Configuration reset values.
  localparam logic [7:0] THRESHOLD_RESET  = 8'd16;
  localparam logic [3:0] MIN_ACTIVE_RESET = 4'd2;

  typedef struct packed {
    logic [7:0] threshold;
    logic [3:0] min_active;
  } bmm_cfg_t;

  // One classified request as it travels from the front to the back part.
  typedef struct packed {
    logic              is_query;
    logic [7:0]        diff;
    logic              cell_first;
    logic              seg_first;
    logic              seg_last;
    logic              cell_done;
    logic              have_prev;
    logic              last_cell;
    logic [CIDX_W-1:0] cx;
    logic [CIDX_W-1:0] cy;
    logic [2:0]        row_ok;
    logic [2:0]        col_ok;
  } bmm_item_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic       cell_moving;
    logic       has_motion;
    logic [3:0] neighbour_count;
    logic       last_of_frame;
  } bmm_result_t;

endpackage

// ===== sv/bmm_fifo.sv =====
// ----------------------------------------------------------------------------
// bmm_fifo
// Small synchronous queue with a combinational head and a fill level.
// ----------------------------------------------------------------------------
module bmm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         empty,
  output logic                         full,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             push_ok;
  logic             pop_ok;

  assign empty   = (level == '0);
  assign full    = (level == LW'(DEPTH));
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = store[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      level <= level + LW'(push_ok) - LW'(pop_ok);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      store[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== sv/bmm_front.sv =====
// ----------------------------------------------------------------------------
// bmm_front
// Accepts requests, tracks the raster position, keeps the previous frame and
// classifies each pixel or query before handing it to the item queue.
// ----------------------------------------------------------------------------
module bmm_front #(
  parameter int FRAME_W = 96,
  parameter int FRAME_H = 96,
  parameter int CELL    = 8,
  parameter int GRID_W  = 12,
  parameter int GRID_H  = 12
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         push,
  output logic                                         full,
  input  logic                                         func,
  input  logic [7:0]                                   pixel,
  input  logic                                         update_prev,
  input  logic [6:0]                                   query_x,
  input  logic [6:0]                                   query_y,
  input  logic [$clog2(bmm_pkg::ITEM_QUEUE_DEPTH+1)-1:0] q_level,
  output logic                                         q_push,
  output bmm_pkg::bmm_item_t                           q_item
);

  import bmm_pkg::*;

  localparam int COL_W   = $clog2(FRAME_W);
  localparam int ROW_W   = $clog2(FRAME_H);
  localparam int PA_W    = $clog2(FRAME_W*FRAME_H);
  localparam int LX_W    = $clog2(CELL);
  localparam int GXC_W   = (FRAME_W/CELL > 0) ? $clog2(FRAME_W/CELL + 1) : 1;
  localparam int GYC_W   = (FRAME_H/CELL > 0) ? $clog2(FRAME_H/CELL + 1) : 1;
  localparam int NCX     = (GRID_W < FRAME_W/CELL) ? GRID_W : FRAME_W/CELL;
  localparam int NCY     = (GRID_H < FRAME_H/CELL) ? GRID_H : FRAME_H/CELL;
  localparam int RECIP_SH = 20;
  localparam int RECIP   = (2**RECIP_SH + CELL - 1) / CELL;
  localparam int PROD_W  = 7 + RECIP_SH;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [LX_W-1:0]  lx;
  logic [LX_W-1:0]  ly;
  logic [GXC_W-1:0] gx;
  logic [GYC_W-1:0] gy;
  logic [PA_W-1:0]  pix_addr;
  logic             have_prev;

  logic             accept;
  logic             is_query;
  logic             last_col;
  logic             last_row;
  logic             lx_last;
  logic             ly_last;
  logic             in_grid;
  logic [PROD_W-1:0] qx_prod;
  logic [PROD_W-1:0] qy_prod;
  logic [CIDX_W-1:0] qcx;
  logic [CIDX_W-1:0] qcy;
  logic [2:0]       row_ok;
  logic [2:0]       col_ok;
  bmm_item_t        item_in;

  bmm_item_t        s1_item;
  logic             s1_valid;
  logic [7:0]       s1_pixel;
  logic [7:0]       prev_rd;
  logic [7:0]       prev_mem [FRAME_W*FRAME_H];

  // Room is counted for the entry that is still waiting on the frame store.
  assign full     = (32'(q_level) + 32'(s1_valid)) >= ITEM_QUEUE_DEPTH;
  assign accept   = push && !full;
  assign is_query = (func == FUNC_QUERY);

  // Raster position flags.
  assign last_col = (col == COL_W'(FRAME_W-1));
  assign last_row = (row == ROW_W'(FRAME_H-1));
  assign lx_last  = (lx == LX_W'(CELL-1));
  assign ly_last  = (ly == LX_W'(CELL-1));
  assign in_grid  = (32'(gx) < NCX) && (32'(gy) < NCY);

  // Query point to cell by reciprocal multiplication.
  assign qx_prod = PROD_W'(query_x) * PROD_W'(RECIP);
  assign qy_prod = PROD_W'(query_y) * PROD_W'(RECIP);
  assign qcx     = CIDX_W'(qx_prod >> RECIP_SH);
  assign qcy     = CIDX_W'(qy_prod >> RECIP_SH);

  // Which neighbour rows and columns lie inside the grid.
  always_comb begin
    row_ok[0] = (qcy != '0) && ({1'b0, qcy} <= 8'(GRID_H));
    row_ok[1] = ({1'b0, qcy} < 8'(GRID_H));
    row_ok[2] = (({1'b0, qcy} + 8'd1) < 8'(GRID_H));
    col_ok[0] = (qcx != '0) && ({1'b0, qcx} <= 8'(GRID_W));
    col_ok[1] = ({1'b0, qcx} < 8'(GRID_W));
    col_ok[2] = (({1'b0, qcx} + 8'd1) < 8'(GRID_W));
  end

  // Classification of the incoming request.
  always_comb begin
    item_in            = '0;
    item_in.is_query   = is_query;
    item_in.cell_first = (lx == '0) && (ly == '0);
    item_in.seg_first  = (lx == '0);
    item_in.seg_last   = lx_last;
    item_in.cell_done  = lx_last && ly_last;
    item_in.have_prev  = have_prev;
    item_in.last_cell  = (32'(gx) == GRID_W-1) && (32'(gy) == GRID_H-1);
    if (is_query) begin
      item_in.cx     = qcx;
      item_in.cy     = qcy;
      item_in.row_ok = row_ok;
      item_in.col_ok = col_ok;
    end else begin
      item_in.cx = CIDX_W'(gx);
      item_in.cy = CIDX_W'(gy);
    end
  end

  // Raster counters advance on every accepted pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      lx        <= '0;
      ly        <= '0;
      gx        <= '0;
      gy        <= '0;
      pix_addr  <= '0;
      have_prev <= 1'b0;
    end else if (accept && !is_query) begin
      if (last_col) begin
        col <= '0;
        lx  <= '0;
        gx  <= '0;
        if (last_row) begin
          row       <= '0;
          ly        <= '0;
          gy        <= '0;
          pix_addr  <= '0;
          have_prev <= 1'b1;
        end else begin
          row      <= row + ROW_W'(1);
          ly       <= ly_last ? '0 : ly + LX_W'(1);
          gy       <= gy + GYC_W'(ly_last);
          pix_addr <= pix_addr + PA_W'(1);
        end
      end else begin
        col      <= col + COL_W'(1);
        lx       <= lx_last ? '0 : lx + LX_W'(1);
        gx       <= gx + GXC_W'(lx_last);
        pix_addr <= pix_addr + PA_W'(1);
      end
    end
  end

  // Previous frame store: read the old value, then replace it if asked.
  always_ff @(posedge clk) begin
    if (accept && !is_query) begin
      prev_rd <= prev_mem[pix_addr];
      if (update_prev) begin
        prev_mem[pix_addr] <= pixel;
      end
    end
  end

  // Holding stage while the frame store read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (is_query || in_grid);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item  <= item_in;
      s1_pixel <= pixel;
    end
  end

  // Absolute difference joins the entry on its way into the queue.
  always_comb begin
    q_item      = s1_item;
    q_item.diff = (s1_pixel > prev_rd) ? (s1_pixel - prev_rd) : (prev_rd - s1_pixel);
  end

  assign q_push = s1_valid;

endmodule

// ===== sv/bmm_back.sv =====
// ----------------------------------------------------------------------------
// bmm_back
// Executes classified requests: accumulates cell sums, updates the motion
// map and answers neighbourhood queries.
// ----------------------------------------------------------------------------
module bmm_back #(
  parameter int FRAME_W = 96,
  parameter int FRAME_H = 96,
  parameter int CELL    = 8,
  parameter int GRID_W  = 12,
  parameter int GRID_H  = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bmm_pkg::bmm_cfg_t    cfg,
  input  logic                 q_empty,
  input  bmm_pkg::bmm_item_t   q_item,
  output logic                 q_pop,
  input  logic                 r_full,
  output logic                 r_push,
  output bmm_pkg::bmm_result_t r_item
);

  import bmm_pkg::*;

  localparam int SUM_W     = $clog2(CELL*CELL*255 + 1);
  localparam int GX_W      = (GRID_W > 1) ? $clog2(GRID_W) : 1;
  localparam int MAP_DEPTH = (GRID_H + 3) / 4;
  localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int NCX       = (GRID_W < FRAME_W/CELL) ? GRID_W : FRAME_W/CELL;
  localparam int NCY       = (GRID_H < FRAME_H/CELL) ? GRID_H : FRAME_H/CELL;

  bmm_item_t         b_item;
  logic              b_valid;
  logic              b_res;
  logic              b_go;

  // Cell sum store and segment accumulator.
  logic [SUM_W-1:0]  sums_mem [GRID_W];
  logic [SUM_W-1:0]  sums_rd;
  logic              sums_fwd_v;
  logic [SUM_W-1:0]  sums_fwd_d;
  logic [SUM_W-1:0]  acc;
  logic [SUM_W-1:0]  base;
  logic [SUM_W-1:0]  sum;
  logic              s_we;
  logic [GX_W-1:0]   s_wa;
  logic              moving;

  // Motion map in four row banks, so three adjacent rows read at once.
  logic [GRID_W-1:0] map_mem [4][MAP_DEPTH];
  logic [GRID_W-1:0] map_rd [4];
  logic [MAP_AW-1:0] map_addr [4];
  logic [7:0]        hr [3];
  logic              m_we;
  logic              map_fwd_v;
  logic [CIDX_W-1:0] map_fwd_row;
  logic [CIDX_W-1:0] map_fwd_col;
  logic              map_fwd_bit;

  // Map fill position: entries not yet written read as set.
  logic [7:0]        fill_x;
  logic [7:0]        fill_y;
  logic              fill_full;

  // Query evaluation.
  logic [7:0]        br;
  logic [7:0]        bc;
  logic [GRID_W-1:0] row_bits;
  logic              nb_bit;
  logic              nb_written;
  logic [3:0]        count;

  assign b_res = b_item.is_query || b_item.cell_done;
  assign b_go  = b_valid && (!b_res || !r_full);
  assign q_pop = !q_empty && (!b_valid || b_go);

  // Execute stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (q_pop) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_item <= q_item;
    end
  end

  // Sum of the current cell so far, including this pixel.
  always_comb begin
    if (b_item.cell_first) begin
      base = '0;
    end else if (b_item.seg_first) begin
      base = sums_fwd_v ? sums_fwd_d : sums_rd;
    end else begin
      base = acc;
    end
    sum    = base + SUM_W'(b_item.diff);
    moving = !b_item.have_prev ||
             ((SUM_W+8)'(sum >> MOTION_SHIFT) >= (SUM_W+8)'(cfg.threshold));
  end

  assign s_we = b_go && !b_item.is_query && b_item.seg_last;
  assign s_wa = b_item.cx[GX_W-1:0];
  assign m_we = b_go && !b_item.is_query && b_item.cell_done;

  always_ff @(posedge clk) begin
    if (b_go && !b_item.is_query) begin
      acc <= sum;
    end
  end

  // Cell sum store with a bypass for a write in the same cycle as the read.
  always_ff @(posedge clk) begin
    if (s_we) begin
      sums_mem[s_wa] <= sum;
    end
    if (q_pop) begin
      sums_rd    <= sums_mem[q_item.cx[GX_W-1:0]];
      sums_fwd_v <= s_we && (s_wa == q_item.cx[GX_W-1:0]);
      sums_fwd_d <= sum;
    end
  end

  // Row addresses of the three neighbour rows of the next entry.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hr[k] = {1'b0, q_item.cy} + 8'(k) + 8'hFF;
    end
    for (int b = 0; b < 4; b++) begin
      map_addr[b] = '0;
      for (int k = 0; k < 3; k++) begin
        if (hr[k][1:0] == 2'(b)) begin
          map_addr[b] = hr[k][MAP_AW+1:2];
        end
      end
    end
  end

  // Motion map banks, with the concurrent write kept for forwarding.
  always_ff @(posedge clk) begin
    if (m_we) begin
      map_mem[b_item.cy[1:0]][b_item.cy[MAP_AW+1:2]][b_item.cx[GX_W-1:0]] <= moving;
    end
    if (q_pop) begin
      for (int b = 0; b < 4; b++) begin
        map_rd[b] <= map_mem[b][map_addr[b]];
      end
      map_fwd_v   <= m_we;
      map_fwd_row <= b_item.cy;
      map_fwd_col <= b_item.cx;
      map_fwd_bit <= moving;
    end
  end

  // Cells complete in raster order, so a position marks what has been written.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_x    <= '0;
      fill_y    <= '0;
      fill_full <= 1'b0;
    end else if (m_we) begin
      if (32'(b_item.cx) == NCX-1) begin
        fill_x <= '0;
        fill_y <= {1'b0, b_item.cy} + 8'd1;
        if (32'(b_item.cy) == NCY-1) begin
          fill_full <= 1'b1;
        end
      end else begin
        fill_x <= {1'b0, b_item.cx} + 8'd1;
      end
    end
  end

  // Count of set cells in the clipped neighbourhood.
  always_comb begin
    count      = '0;
    br         = '0;
    bc         = '0;
    row_bits   = '0;
    nb_bit     = 1'b0;
    nb_written = 1'b0;
    for (int k = 0; k < 3; k++) begin
      br       = {1'b0, b_item.cy} + 8'(k) + 8'hFF;
      row_bits = map_rd[br[1:0]];
      for (int d = 0; d < 3; d++) begin
        bc         = {1'b0, b_item.cx} + 8'(d) + 8'hFF;
        nb_bit     = row_bits[bc[GX_W-1:0]];
        nb_written = (bc < 8'(NCX)) && (br < 8'(NCY)) &&
                     (fill_full || (br < fill_y) || ((br == fill_y) && (bc < fill_x)));
        if (map_fwd_v && ({1'b0, map_fwd_row} == br) && ({1'b0, map_fwd_col} == bc)) begin
          nb_bit = map_fwd_bit;
        end
        if (!nb_written) begin
          nb_bit = 1'b1;
        end
        if (b_item.row_ok[k] && b_item.col_ok[d]) begin
          count = count + 4'(nb_bit);
        end
      end
    end
  end

  // Result record.
  always_comb begin
    r_item        = '0;
    r_item.cell_x = b_item.cx[3:0];
    r_item.cell_y = b_item.cy[3:0];
    if (b_item.is_query) begin
      r_item.kind            = KIND_QUERY;
      r_item.has_motion      = (count >= cfg.min_active);
      r_item.neighbour_count = count;
    end else begin
      r_item.kind          = KIND_CELL;
      r_item.cell_moving   = moving;
      r_item.last_of_frame = b_item.last_cell;
    end
  end

  assign r_push = b_go && b_res;

endmodule

// ===== sv/block_motion_mask.sv =====
// Path: an accepted request passes the holding stage, the item queue and the
// execute stage register before its result enters the output queue.
// Throughput: one pixel or query per cycle while nothing stalls, set by the
// single-port frame store and the one-entry-per-cycle execute stage.
// Reset: synchronous, clears queues, raster counters and map fill state; the
// motion map reads as all set until written, the frame store is not cleared.
// ----------------------------------------------------------------------------
// block_motion_mask
// Frame-difference block SAD motion detector with a cell motion map and
// neighbourhood motion queries.
// ----------------------------------------------------------------------------
module block_motion_mask #(
  parameter int FRAME_W = 96,
  parameter int FRAME_H = 96,
  parameter int CELL    = 8,
  parameter int GRID_W  = 12,
  parameter int GRID_H  = 12
) (
  input  logic       clk,
  input  logic       rst,
  // Request side
  input  logic       push,
  output logic       full,
  input  logic       func,
  input  logic [7:0] pixel,
  input  logic       update_prev,
  input  logic [6:0] query_x,
  input  logic [6:0] query_y,
  // Result side
  output logic       empty,
  input  logic       pop,
  output logic       kind,
  output logic [3:0] cell_x,
  output logic [3:0] cell_y,
  output logic       cell_moving,
  output logic       has_motion,
  output logic [3:0] neighbour_count,
  output logic       last_of_frame,
  // Configuration
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  import bmm_pkg::*;

  localparam int ITEM_W   = $bits(bmm_item_t);
  localparam int RESULT_W = $bits(bmm_result_t);
  localparam int QL_W     = $clog2(ITEM_QUEUE_DEPTH + 1);

  bmm_cfg_t          cfg;
  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  logic [QL_W-1:0]   q_level;
  bmm_item_t         q_in;
  bmm_item_t         q_out;
  logic [ITEM_W-1:0] q_rdata;
  logic              r_push;
  logic              r_full;
  bmm_result_t       r_in;
  bmm_result_t       r_out;
  logic [RESULT_W-1:0] r_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold  <= THRESHOLD_RESET;
      cfg.min_active <= MIN_ACTIVE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THRESHOLD:  cfg.threshold  <= cfg_data;
        REG_MIN_ACTIVE: cfg.min_active <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Front part: raster tracking, frame store, classification.
  bmm_front #(
    .FRAME_W (FRAME_W),
    .FRAME_H (FRAME_H),
    .CELL    (CELL),
    .GRID_W  (GRID_W),
    .GRID_H  (GRID_H)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .pixel       (pixel),
    .update_prev (update_prev),
    .query_x     (query_x),
    .query_y     (query_y),
    .q_level     (q_level),
    .q_push      (q_push),
    .q_item      (q_in)
  );

  // Item queue between the two parts; room is judged from its fill level.
  bmm_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (ITEM_QUEUE_DEPTH)
  ) u_item_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_in),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (),
    .level (q_level)
  );

  assign q_out = bmm_item_t'(q_rdata);

  // Back part: accumulation, motion map and queries.
  bmm_back #(
    .FRAME_W (FRAME_W),
    .FRAME_H (FRAME_H),
    .CELL    (CELL),
    .GRID_W  (GRID_W),
    .GRID_H  (GRID_H)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_item  (q_out),
    .q_pop   (q_pop),
    .r_full  (r_full),
    .r_push  (r_push),
    .r_item  (r_in)
  );

  // Result queue towards the consumer.
  bmm_fifo #(
    .WIDTH (RESULT_W),
    .DEPTH (RESULT_QUEUE_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .wdata (r_in),
    .pop   (pop),
    .rdata (r_rdata),
    .empty (empty),
    .full  (r_full),
    .level ()
  );

  assign r_out           = bmm_result_t'(r_rdata);
  assign kind            = r_out.kind;
  assign cell_x          = r_out.cell_x;
  assign cell_y          = r_out.cell_y;
  assign cell_moving     = r_out.cell_moving;
  assign has_motion      = r_out.has_motion;
  assign neighbour_count = r_out.neighbour_count;
  assign last_of_frame   = r_out.last_of_frame;

endmodule

// ===== verif/block_motion_mask_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_motion_mask_tb
// Self-checking bench for the block motion mask. Whole frames of grey pixels
// are streamed in with a per-cell scene plan, so that cells are still, noisy,
// flat, inverted or shifted around the threshold. Neighbourhood queries are mixed in.
// A predictor in the bench works out every cell result and query answer, and
// each popped result is compared with the oldest one it predicted. Both
// queue sides idle at random. There is one long receiver hold-off, and the
// registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module block_motion_mask_tb;
  import bmm_pkg::*;

  localparam int FRAME_W = 96;
  localparam int FRAME_H = 96;
  localparam int CELL    = 8;
  localparam int GRID_W  = 12;
  localparam int GRID_H  = 12;

  localparam logic FUNC_PIXEL = ~FUNC_QUERY;

  // Slack after the last result.
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 100000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    logic       func;
    logic [7:0] pixel;
    logic       update_prev;
    logic [6:0] query_x;
    logic [6:0] query_y;
  } request_t;

  typedef enum int {
    SCENE_SAME,
    SCENE_NOISE,
    SCENE_FLAT,
    SCENE_SHIFT,
    SCENE_INVERT
  } scene_e;

  logic       clk;
  logic       rst         = 1'b1;
  logic       push        = 1'b0;
  logic       full;
  logic       func        = FUNC_PIXEL;
  logic [7:0] pixel       = 8'd0;
  logic       update_prev = 1'b0;
  logic [6:0] query_x     = 7'd0;
  logic [6:0] query_y     = 7'd0;
  logic       empty;
  logic       pop         = 1'b0;
  logic       kind;
  logic [3:0] cell_x;
  logic [3:0] cell_y;
  logic       cell_moving;
  logic       has_motion;
  logic [3:0] neighbour_count;
  logic       last_of_frame;
  logic       cfg_write   = 1'b0;
  logic       cfg_index   = REG_THRESHOLD;
  logic [7:0] cfg_data    = 8'd0;

  // Predicted state of the block.
  logic [7:0]  prev_store [FRAME_W*FRAME_H];
  logic [13:0] sad_sums [GRID_W];
  bit          motion_cells [GRID_W*GRID_H];
  bit          seen_frame;
  int          raster_col;
  int          raster_row;
  logic [7:0]  thr_reg;
  logic [3:0]  min_reg;

  bmm_result_t motion_results [$];

  // Scene plan of the frame being streamed.
  scene_e      cell_scene [GRID_W*GRID_H];
  logic [7:0]  cell_level [GRID_W*GRID_H];
  int          cell_shift [GRID_W*GRID_H];

  int          error_count = 0;
  bit          offering    = 1'b0;
  bit          both_calm   = 1'b0;
  bit          rx_hold_req = 1'b0;
  int          rx_hold_len = 0;

  block_motion_mask #(
    .FRAME_W(FRAME_W),
    .FRAME_H(FRAME_H),
    .CELL(CELL),
    .GRID_W(GRID_W),
    .GRID_H(GRID_H)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .func(func),
    .pixel(pixel),
    .update_prev(update_prev),
    .query_x(query_x),
    .query_y(query_y),
    .empty(empty),
    .pop(pop),
    .kind(kind),
    .cell_x(cell_x),
    .cell_y(cell_y),
    .cell_moving(cell_moving),
    .has_motion(has_motion),
    .neighbour_count(neighbour_count),
    .last_of_frame(last_of_frame),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor: advances the bench's copy of the block by one request and
  // queues the result it causes, if any.
  task automatic track_motion(input request_t r);
    bmm_result_t res;
    int          cx;
    int          cy;
    int          count;
    int          idx;
    int          gx;
    int          gy;
    logic [7:0]  old;
    logic [7:0]  diff;
    bit          moving;
    res = '0;
    if (r.func == FUNC_QUERY) begin
      // Count set map cells in the 3x3 neighbourhood, clipped at the edges.
      cx = r.query_x / CELL;
      cy = r.query_y / CELL;
      count = 0;
      for (int ny = cy - 1; ny <= cy + 1; ny++) begin
        for (int nx = cx - 1; nx <= cx + 1; nx++) begin
          if (ny >= 0 && ny < GRID_H && nx >= 0 && nx < GRID_W) begin
            count += motion_cells[ny*GRID_W + nx];
          end
        end
      end
      res.kind            = KIND_QUERY;
      res.cell_x          = cx[3:0];
      res.cell_y          = cy[3:0];
      res.has_motion      = (count >= min_reg);
      res.neighbour_count = count[3:0];
      motion_results.push_back(res);
    end else begin
      idx = raster_row*FRAME_W + raster_col;
      gx  = raster_col / CELL;
      gy  = raster_row / CELL;
      // Pixels of partial cells or beyond the grid add to no cell; they still advance the raster.
      if (gx < GRID_W && gy < GRID_H && (gx + 1)*CELL <= FRAME_W &&
          (gy + 1)*CELL <= FRAME_H) begin
        old  = prev_store[idx];
        diff = (r.pixel > old) ? r.pixel - old : old - r.pixel;
        if (raster_col % CELL == 0 && raster_row % CELL == 0) begin
          sad_sums[gx] = 14'(diff);
        end else begin
          sad_sums[gx] = sad_sums[gx] + 14'(diff);
        end
        if (raster_col % CELL == CELL - 1 && raster_row % CELL == CELL - 1) begin
          // Until a whole frame has been streamed every cell counts as moving.
          moving = seen_frame ? ((sad_sums[gx] >> MOTION_SHIFT) >= thr_reg) : 1'b1;
          motion_cells[gy*GRID_W + gx] = moving;
          res.kind          = KIND_CELL;
          res.cell_x        = gx[3:0];
          res.cell_y        = gy[3:0];
          res.cell_moving   = moving;
          res.last_of_frame = (gx == GRID_W - 1 && gy == GRID_H - 1);
          motion_results.push_back(res);
        end
      end
      if (r.update_prev) begin
        prev_store[idx] = r.pixel;
      end
      if (raster_col + 1 >= FRAME_W) begin
        raster_col = 0;
        if (raster_row + 1 >= FRAME_H) begin
          raster_row = 0;
          seen_frame = 1'b1;
        end else begin
          raster_row++;
        end
      end else begin
        raster_col++;
      end
    end
  endtask

  function automatic request_t query_at(input int x, input int y);
    request_t r;
    r.func        = FUNC_QUERY;
    r.pixel       = 8'($urandom_range(255));
    r.update_prev = 1'($urandom_range(1));
    r.query_x     = 7'(x);
    r.query_y     = 7'(y);
    return r;
  endfunction

  // Mostly points inside the frame, a quarter anywhere the field allows.
  function automatic request_t random_query();
    if ($urandom_range(3) == 0) begin
      return query_at($urandom_range(127), $urandom_range(127));
    end
    return query_at($urandom_range(FRAME_W - 1), $urandom_range(FRAME_H - 1));
  endfunction

  function automatic logic [7:0] random_threshold();
    if ($urandom_range(3) == 0) begin
      return 8'($urandom_range(255));
    end
    return 8'($urandom_range(12));
  endfunction

  // Offer one request and wait until it is accepted, idling first at random.
  task automatic send_request(input request_t r);
    int gap;
    gap = 0;
    while (!both_calm && $urandom_range(99) < 28) begin
      gap++;
    end
    if (gap > 0) begin
      if (offering) begin
        push <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    func        <= r.func;
    pixel       <= r.pixel;
    update_prev <= r.update_prev;
    query_x     <= r.query_x;
    query_y     <= r.query_y;
    offering = 1'b1;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    track_motion(r);
  endtask

  task automatic stop_requests();
    if (offering) begin
      push <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Let every predicted result come out, then give the pipeline time to empty.
  task automatic drain_results();
    stop_requests();
    while (motion_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [7:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_THRESHOLD) begin
      thr_reg = data;
    end else begin
      min_reg = data[3:0];
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Give each cell a behaviour for the coming frame.
  task automatic plan_scene();
    int d;
    for (int c = 0; c < GRID_W*GRID_H; c++) begin
      cell_scene[c] = scene_e'($urandom_range(4));
      case ($urandom_range(2))
        0:       cell_level[c] = 8'd0;
        1:       cell_level[c] = 8'd255;
        default: cell_level[c] = 8'($urandom_range(255));
      endcase
      d = int'(thr_reg) + $urandom_range(4) - 2;
      cell_shift[c] = (d < 0) ? 0 : ((d > 255) ? 255 : d);
    end
  endtask

  function automatic logic [7:0] scene_pixel(input int row, input int col);
    int         c;
    int         v;
    logic [7:0] old;
    c   = (row / CELL)*GRID_W + col / CELL;
    old = prev_store[row*FRAME_W + col];
    case (cell_scene[c])
      SCENE_SAME:   return old;
      SCENE_NOISE:  return 8'($urandom_range(255));
      SCENE_FLAT:   return cell_level[c];
      SCENE_INVERT: return (old < 8'd128) ? 8'd255 : 8'd0;
      default: begin
        v = $urandom_range(1) ? int'(old) + cell_shift[c] : int'(old) - cell_shift[c];
        v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
        return 8'(v);
      end
    endcase
  endfunction

  // Stream pixels up to the end of the current frame with queries mixed in, retuning halfway if asked.
  task automatic send_frame(input int update_pct, input int query_pct,
                            input bit retune_mid, input int calm_rows);
    request_t r;
    bit       begun;
    bit       retuned;
    begun   = 1'b0;
    retuned = 1'b0;
    plan_scene();
    while (!begun || raster_col != 0 || raster_row != 0) begin
      both_calm = (raster_row < calm_rows);
      if (retune_mid && !retuned && raster_row == FRAME_H/2 && raster_col == 0) begin
        retuned = 1'b1;
        drain_results();
        write_register(REG_THRESHOLD, random_threshold());
        write_register(REG_MIN_ACTIVE, 8'($urandom_range(255)));
      end
      if ($urandom_range(99) < query_pct) begin
        send_request(random_query());
      end else begin
        r.func        = FUNC_PIXEL;
        r.pixel       = scene_pixel(raster_row, raster_col);
        r.update_prev = ($urandom_range(99) < update_pct);
        r.query_x     = 7'($urandom_range(127));
        r.query_y     = 7'($urandom_range(127));
        send_request(r);
        begun = 1'b1;
      end
    end
    both_calm = 1'b0;
  endtask

  // Queries against the all-set map after reset, across the count limits.
  task automatic test_reset_map_queries();
    request_t r;
    send_request(query_at(0, 0));
    send_request(query_at(95, 95));
    send_request(query_at(127, 127));
    send_request(query_at(95, 0));
    send_request(query_at(0, 95));
    send_request(query_at(50, 50));
    send_request(query_at(96, 96));
    drain_results();
    write_register(REG_MIN_ACTIVE, 8'h09);
    send_request(query_at(50, 50));
    send_request(query_at(0, 0));
    drain_results();
    // A minimum of zero lets even an empty neighbourhood report motion.
    write_register(REG_MIN_ACTIVE, 8'hA0);
    send_request(query_at(127, 127));
    send_request(query_at(127, 0));
    drain_results();
    write_register(REG_MIN_ACTIVE, 8'hFF);
    send_request(query_at(50, 50));
    drain_results();
    write_register(REG_THRESHOLD, 8'd255);
    write_register(REG_THRESHOLD, 8'd0);
    write_register(REG_THRESHOLD, THRESHOLD_RESET);
    write_register(REG_MIN_ACTIVE, {4'd0, MIN_ACTIVE_RESET});
    // Pixel extremes open the first frame; all of it must be stored.
    r.func        = FUNC_PIXEL;
    r.update_prev = 1'b1;
    r.query_x     = 7'd127;
    r.query_y     = 7'd0;
    for (int i = 0; i < 4; i++) begin
      r.pixel = (i % 2 == 0) ? 8'd0 : 8'd255;
      send_request(r);
    end
  endtask

  // Every cell of the first frame must report motion whatever its content.
  task automatic test_first_frame();
    send_frame(100, 2, 1'b0, 0);
    drain_results();
  endtask

  // First compared frame at reset settings, starting with a stretch of no idling.
  task automatic test_settled_frame();
    write_register(REG_THRESHOLD, THRESHOLD_RESET);
    send_frame(100, 2, 1'b0, 24);
    drain_results();
  endtask

  // The receiver holds off while queries keep coming, so the block fills up.
  task automatic test_backpressure();
    rx_hold_len = 300;
    rx_hold_req = ~rx_hold_req;
    for (int i = 0; i < 80; i++) begin
      send_request(random_query());
    end
    drain_results();
  endtask

  task automatic test_threshold_extremes();
    write_register(REG_THRESHOLD, 8'd255);
    write_register(REG_MIN_ACTIVE, 8'h01);
    send_frame(80, 2, 1'b0, 0);
    drain_results();
    write_register(REG_THRESHOLD, 8'd0);
    write_register(REG_MIN_ACTIVE, 8'h59);
    send_frame(50, 2, 1'b0, 0);
    drain_results();
  endtask

  task automatic test_random_settings();
    write_register(REG_THRESHOLD, random_threshold());
    write_register(REG_MIN_ACTIVE, 8'($urandom_range(255)));
    send_frame($urandom_range(100), 2, 1'b1, 0);
    drain_results();
  endtask

  // Stimulus and end of run.
  initial begin : stimulus
    int waited;
    foreach (prev_store[i]) prev_store[i] = 8'd0;
    foreach (sad_sums[i]) sad_sums[i] = '0;
    foreach (motion_cells[i]) motion_cells[i] = 1'b1;
    seen_frame = 1'b0;
    raster_col = 0;
    raster_row = 0;
    thr_reg    = THRESHOLD_RESET;
    min_reg    = MIN_ACTIVE_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_map_queries();
    test_first_frame();
    test_settled_frame();
    test_backpressure();
    test_threshold_extremes();
    test_random_settings();

    stop_requests();
    waited = 0;
    while (motion_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (motion_results.size() != 0) begin
      if (error_count < REPORT_LIMIT) begin
        $display("%0d predicted results never came out", motion_results.size());
      end
      error_count += motion_results.size();
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  function automatic string show_result(input bmm_result_t r);
    return $sformatf("kind %0d x %0d y %0d moving %0d hit %0d count %0d last %0d",
                     r.kind, r.cell_x, r.cell_y, r.cell_moving, r.has_motion,
                     r.neighbour_count, r.last_of_frame);
  endfunction

  // Result side: checks each popped result and decides pop for the next edge.
  initial begin : result_check
    bmm_result_t seen;
    bmm_result_t want;
    bit          hold_seen;
    int          hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    @(posedge clk);
    while (rst) begin
      @(posedge clk);
    end
    forever begin
      if (pop && !empty) begin
        seen = {kind, cell_x, cell_y, cell_moving, has_motion, neighbour_count,
                last_of_frame};
        if (motion_results.size() == 0) begin
          if (error_count < REPORT_LIMIT) begin
            $display("t=%0t unexpected result: %s", $realtime, show_result(seen));
          end
          error_count++;
        end else begin
          want = motion_results.pop_front();
          if (seen !== want) begin
            if (error_count < REPORT_LIMIT) begin
              $display("t=%0t mismatch: expected %s", $realtime, show_result(want));
              $display("t=%0t           actual   %s", $realtime, show_result(seen));
            end
            error_count++;
          end
        end
      end
      // A hold-off request from the stimulus starts a counted stall.
      if (rx_hold_req != hold_seen) begin
        hold_seen = rx_hold_req;
        hold_left = rx_hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= both_calm || ($urandom_range(99) >= 28);
      end
      @(posedge clk);
    end
  end

  initial begin : run_limit
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
